// ===== rtl/snd_pkg.sv =====
package snd_pkg;

  localparam int unsigned ReadW     = 16;
  localparam int unsigned FreqW     = 28;
  localparam int unsigned StepW     = 24;
  localparam int unsigned PatW      = 8;
  localparam int unsigned HistOutW  = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 28;
  localparam int unsigned HistLenDef = 8;

  localparam logic [PatW-1:0]  PatFirstRst  = 8'd240;
  localparam logic [PatW-1:0]  PatSecondRst = 8'd242;
  localparam logic [PatW-1:0]  PatThirdRst  = 8'd184;
  localparam logic [StepW-1:0] StepRst      = 24'd233000;
  localparam logic [FreqW-1:0] LimitRst     = 28'hFFFFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_FIRST  = 3'd0,
    REG_PATTERN_SECOND = 3'd1,
    REG_PATTERN_THIRD  = 3'd2,
    REG_STEP_SIZE      = 3'd3,
    REG_SWEEP_LIMIT    = 3'd4
  } snd_reg_e;

  typedef struct packed {
    logic [PatW-1:0]  pattern_first;
    logic [PatW-1:0]  pattern_second;
    logic [PatW-1:0]  pattern_third;
    logic [StepW-1:0] step_size;
    logic [FreqW-1:0] sweep_limit;
  } snd_cfg_t;

  typedef struct packed {
    logic             mode;
    logic [ReadW-1:0] reading_a;
    logic [ReadW-1:0] reading_b;
    logic [FreqW-1:0] frequency;
    logic             restart;
  } snd_item_t;

  typedef struct packed {
    logic                notch_found;
    logic [FreqW-1:0]    notch_frequency;
    logic                end_of_sweep;
    logic [HistOutW-1:0] history_bits;
  } snd_result_t;

endpackage

// ===== rtl/snd_if.sv =====
interface snd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [snd_pkg::ReadW-1:0]  reading_a;
  logic [snd_pkg::ReadW-1:0]  reading_b;
  logic [snd_pkg::FreqW-1:0]  frequency;
  logic                       restart;

  modport source (output valid, mode, reading_a, reading_b, frequency, restart,
                  input ready);
  modport sink   (input valid, mode, reading_a, reading_b, frequency, restart,
                  output ready);
endinterface

interface snd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          notch_found;
  logic [snd_pkg::FreqW-1:0]     notch_frequency;
  logic                          end_of_sweep;
  logic [snd_pkg::HistOutW-1:0]  history_bits;

  modport source (output valid, notch_found, notch_frequency, end_of_sweep,
                  history_bits, input ready);
  modport sink   (input valid, notch_found, notch_frequency, end_of_sweep,
                  history_bits, output ready);
endinterface

interface snd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [snd_pkg::CfgIdxW-1:0]   index;
  logic [snd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/snd_cfg_regs.sv =====
module snd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  snd_cfg_if.sink           cfg_i,
  output snd_pkg::snd_cfg_t cfg_o
);
  import snd_pkg::*;

  snd_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PATTERN_FIRST:  cfg_d.pattern_first  = cfg_i.data[PatW-1:0];
        REG_PATTERN_SECOND: cfg_d.pattern_second = cfg_i.data[PatW-1:0];
        REG_PATTERN_THIRD:  cfg_d.pattern_third  = cfg_i.data[PatW-1:0];
        REG_STEP_SIZE:      cfg_d.step_size      = cfg_i.data[StepW-1:0];
        REG_SWEEP_LIMIT:    cfg_d.sweep_limit    = cfg_i.data[FreqW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_first  <= PatFirstRst;
      cfg_q.pattern_second <= PatSecondRst;
      cfg_q.pattern_third  <= PatThirdRst;
      cfg_q.step_size      <= StepRst;
      cfg_q.sweep_limit    <= LimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/snd_core.sv =====
module snd_core #(
  parameter int unsigned HistLen = snd_pkg::HistLenDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  snd_pkg::snd_item_t   item_i,
  input  snd_pkg::snd_cfg_t    cfg_i,
  output snd_pkg::snd_result_t result_o
);
  import snd_pkg::*;

  localparam int unsigned CmpW  = (HistLen > PatW) ? HistLen : PatW;
  localparam int unsigned Back  = HistLen / 2;
  localparam int unsigned BackW = StepW + $clog2(Back + 1);
  localparam int unsigned SubW  = (BackW > FreqW) ? BackW : FreqW;

  logic [HistLen-1:0] hist_q, hist_d, hist_base, hist;
  logic [ReadW-1:0]   prev_q, prev_d, prev_eff, value;
  logic [CmpW-1:0]    hist_ext;
  logic               match, found;
  logic [BackW-1:0]   back;
  logic [SubW-1:0]    freq_ext, back_ext, diff;
  logic [FreqW:0]     reach;

  always_comb begin
    value     = (item_i.mode && (item_i.reading_b < item_i.reading_a)) ?
                item_i.reading_b : item_i.reading_a;
    prev_eff  = item_i.restart ? {ReadW{1'b1}} : prev_q;
    hist_base = item_i.restart ? '0 : hist_q;
    hist      = {hist_base[HistLen-2:0], prev_eff >= value};
    hist_ext  = CmpW'(hist);
    match     = (hist_ext == CmpW'(cfg_i.pattern_first))  ||
                (hist_ext == CmpW'(cfg_i.pattern_second)) ||
                (hist_ext == CmpW'(cfg_i.pattern_third));
    found     = (cfg_i.step_size != '0) && match;

    back      = BackW'(cfg_i.step_size) * BackW'(Back);
    freq_ext  = SubW'(item_i.frequency);
    back_ext  = SubW'(back);
    diff      = freq_ext - back_ext;
    reach     = {1'b0, item_i.frequency} + (FreqW + 1)'(cfg_i.step_size);

    result_o.notch_found     = found;
    result_o.notch_frequency = (found && (freq_ext >= back_ext)) ? diff[FreqW-1:0] : '0;
    result_o.end_of_sweep    = !found && (reach > {1'b0, cfg_i.sweep_limit});
    result_o.history_bits    = HistOutW'(hist);

    prev_d = prev_q;
    hist_d = hist_q;
    if (fire_i) begin
      prev_d = value;
      hist_d = found ? '0 : hist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      prev_q <= {ReadW{1'b1}};
    end else begin
      hist_q <= hist_d;
      prev_q <= prev_d;
    end
  end

endmodule

// ===== rtl/sweep_notch_detector.sv =====
// An item passes the input register and then the result register; a stall on the output
// side can hold it in the input register until the result register is free.
// One item per cycle unless the output stalls; history update and pattern match are
// combinational. An empty input stage takes a new item while a result waits at the output.
// Reset (async, active low): history 0, previous value all ones, registers at defaults,
// both pipeline stages empty.
module sweep_notch_detector #(
  parameter int unsigned HistLen = snd_pkg::HistLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  snd_in_if.sink    in_i,
  snd_out_if.source out_o,
  snd_cfg_if.sink   cfg_i
);
  import snd_pkg::*;

  snd_cfg_t    cfg;
  snd_item_t   item_q, item_d;
  snd_result_t res, res_q;
  logic        in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic        adv, fire, in_xfer;

  assign adv      = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && adv;
  assign in_i.ready = !in_valid_q || adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_comb begin
    item_d.mode      = in_i.mode;
    item_d.reading_a = in_i.reading_a;
    item_d.reading_b = in_i.reading_b;
    item_d.frequency = in_i.frequency;
    item_d.restart   = in_i.restart;
    in_valid_d  = in_i.ready ? in_i.valid : in_valid_q;
    out_valid_d = adv ? in_valid_q : out_valid_q;
  end

  snd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  snd_core #(
    .HistLen (HistLen)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.notch_found     = res_q.notch_found;
  assign out_o.notch_frequency = res_q.notch_frequency;
  assign out_o.end_of_sweep    = res_q.end_of_sweep;
  assign out_o.history_bits    = res_q.history_bits;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import snd_pkg::*;

  localparam int unsigned HistLen      = HistLenDef;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseItems   = 140;
  localparam int          NumPhases    = 6;
  localparam int          NumRows      = 24;

  typedef struct packed {
    snd_item_t   sample;
    logic        has_want;
    snd_result_t want;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;

  snd_in_if  in_if ();
  snd_out_if out_if ();
  snd_cfg_if cfg_if ();

  sweep_notch_detector #(
    .HistLen(HistLen)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // detector model state
  snd_cfg_t           cfg_model;
  logic [HistLen-1:0] hist_model;
  logic [ReadW-1:0]   level_model;

  snd_result_t notch_reports_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        steady_flow;
  int          hold_requests;

  // reset, extremes, two of the three notch shapes, clamp, end-of-sweep boundary
  sample_row_t directed_rows [NumRows] = '{
    '{'{1'b0, 16'hFFFF, 16'h0000, 28'd0, 1'b0}, 1'b1, '{1'b0, 28'd0, 1'b0, 8'h01}},
    '{'{1'b1, 16'hFFFF, 16'h0000, 28'hFFFFFFF, 1'b0}, 1'b1, '{1'b0, 28'd0, 1'b1, 8'h03}},
    '{'{1'b1, 16'h0000, 16'hFFFF, 28'd0, 1'b0}, 1'b1, '{1'b0, 28'd0, 1'b0, 8'h07}},
    '{'{1'b0, 16'h0001, 16'hFFFF, 28'd1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'h8000, 16'h7FFF, 28'h5555555, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1000, 16'hAAAA, 28'd10000000, 1'b1}, 1'b0, '0},
    '{'{1'b0, 16'd900, 16'h5555, 28'd10233000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd800, 16'h0000, 28'd10466000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd700, 16'h0000, 28'd10699000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd800, 16'h0000, 28'd10932000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd900, 16'h0000, 28'd11165000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1000, 16'h0000, 28'd11398000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1100, 16'h0000, 28'd500000, 1'b0}, 1'b1, '{1'b1, 28'd0, 1'b0, 8'hF0}},
    '{'{1'b0, 16'd1000, 16'h0000, 28'd20000000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1200, 16'h0000, 28'd20233000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1100, 16'h0000, 28'd20466000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1000, 16'h0000, 28'd20699000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd900, 16'h0000, 28'd20932000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1000, 16'h0000, 28'd21165000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1100, 16'h0000, 28'd21398000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'd1200, 16'h0000, 28'd5000000, 1'b0}, 1'b1,
      '{1'b1, 28'd4068000, 1'b0, 8'hB8}},
    '{'{1'b1, 16'h0000, 16'h0000, 28'hFFFFFFF, 1'b1}, 1'b1, '{1'b0, 28'd0, 1'b1, 8'h01}},
    '{'{1'b0, 16'h0000, 16'h0000, 28'd268202455, 1'b0}, 1'b1,
      '{1'b0, 28'd0, 1'b0, 8'h03}},
    '{'{1'b0, 16'hFFFF, 16'h0000, 28'd268202456, 1'b0}, 1'b1,
      '{1'b0, 28'd0, 1'b1, 8'h06}}
  };

  function automatic snd_result_t predict_notch(input snd_item_t it);
    logic [ReadW-1:0]   lvl;
    logic [HistLen-1:0] h;
    logic [FreqW+1:0]   back;
    snd_result_t        r;
    if (it.restart) begin
      hist_model  = '0;
      level_model = '1;
    end
    lvl = (it.mode && it.reading_b < it.reading_a) ? it.reading_b : it.reading_a;
    h = {hist_model[HistLen-2:0], level_model >= lvl};
    level_model = lvl;
    hist_model  = h;
    r = '0;
    r.history_bits = HistOutW'(h);
    if (cfg_model.step_size != '0 &&
        (h == HistLen'(cfg_model.pattern_first) || h == HistLen'(cfg_model.pattern_second) ||
         h == HistLen'(cfg_model.pattern_third))) begin
      back = (FreqW+2)'(cfg_model.step_size) * (FreqW+2)'(HistLen / 2);
      r.notch_found     = 1'b1;
      r.notch_frequency = ({2'b00, it.frequency} >= back) ? FreqW'(it.frequency - back) : '0;
      hist_model = '0;
    end
    r.end_of_sweep = !r.notch_found &&
                     (({1'b0, it.frequency} + (FreqW+1)'(cfg_model.step_size)) >
                      {1'b0, cfg_model.sweep_limit});
    return r;
  endfunction

  function automatic logic [FreqW-1:0] pick_frequency();
    longint f;
    case ($urandom_range(9))
      0, 1:    f = longint'($urandom_range(4000000, 0));
      2, 3:    f = longint'(cfg_model.sweep_limit) - longint'(cfg_model.step_size) +
                   longint'($urandom_range(4, 0)) - 64'sd2;
      default: f = longint'($urandom & 32'h0FFFFFFF);
    endcase
    if (f < 0) f = 0;
    if (f > longint'(28'hFFFFFFF)) f = longint'(28'hFFFFFFF);
    return f[FreqW-1:0];
  endfunction

  // the used level is lvl; in mode 1 the other reading is never below it
  function automatic snd_item_t make_sample(input logic [ReadW-1:0] lvl, input logic rs);
    snd_item_t        it;
    logic [ReadW-1:0] other;
    it.restart = rs;
    it.mode    = 1'($urandom_range(1));
    other = lvl + ReadW'($urandom_range(32'hFFFF - lvl, 0));
    if (!it.mode) begin
      it.reading_a = lvl;
      it.reading_b = ReadW'($urandom);
    end else if ($urandom_range(1)) begin
      it.reading_a = lvl;
      it.reading_b = other;
    end else begin
      it.reading_a = other;
      it.reading_b = lvl;
    end
    it.frequency = pick_frequency();
    return it;
  endfunction

  function automatic logic [ReadW-1:0] next_level(input logic fall, input logic [ReadW-1:0] prev);
    int unsigned room;
    if (fall) begin
      room = (prev < 3000) ? prev : 3000;
      return prev - ReadW'($urandom_range(room, 0));
    end
    room = 32'hFFFF - prev;
    if (room == 0) return prev;
    return prev + ReadW'($urandom_range((room < 3000) ? room : 3000, 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_notch_report();
    snd_result_t want;
    if (notch_reports_q.size() == 0) begin
      report_mismatch("result transfer with no result expected");
      return;
    end
    want = notch_reports_q.pop_front();
    if (out_if.notch_found !== want.notch_found)
      report_mismatch($sformatf("notch_found 0x%0h expected 0x%0h",
                                out_if.notch_found, want.notch_found));
    if (out_if.notch_frequency !== want.notch_frequency)
      report_mismatch($sformatf("notch_frequency 0x%0h expected 0x%0h",
                                out_if.notch_frequency, want.notch_frequency));
    if (out_if.end_of_sweep !== want.end_of_sweep)
      report_mismatch($sformatf("end_of_sweep 0x%0h expected 0x%0h",
                                out_if.end_of_sweep, want.end_of_sweep));
    if (out_if.history_bits !== want.history_bits)
      report_mismatch($sformatf("history_bits 0x%0h expected 0x%0h",
                                out_if.history_bits, want.history_bits));
  endtask

  task automatic send_sample(input snd_item_t it, input logic has_want,
                             input snd_result_t want);
    snd_result_t predicted;
    in_if.valid     <= 1'b1;
    in_if.mode      <= it.mode;
    in_if.reading_a <= it.reading_a;
    in_if.reading_b <= it.reading_b;
    in_if.frequency <= it.frequency;
    in_if.restart   <= it.restart;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = predict_notch(it);
    notch_reports_q.push_back(has_want ? want : predicted);
  endtask

  task automatic pace_sender();
    if (!steady_flow) begin
      while ($urandom_range(99) < 29) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // eight samples whose slopes spell one of the active patterns
  task automatic send_shaped(inout int unsigned sent);
    logic [PatW-1:0]  pat;
    logic [ReadW-1:0] prev;
    logic             fall;
    logic             rs;
    case ($urandom_range(2))
      0:       pat = cfg_model.pattern_first;
      1:       pat = cfg_model.pattern_second;
      default: pat = cfg_model.pattern_third;
    endcase
    for (int i = int'(HistLen) - 1; i >= 0; i--) begin
      fall = (i < int'(PatW)) ? pat[i] : 1'b0;
      rs   = (i == int'(HistLen) - 1) && fall && ($urandom_range(99) < 20);
      prev = rs ? '1 : level_model;
      pace_sender();
      send_sample(make_sample(next_level(fall, prev), rs), 1'b0, '0);
      sent++;
    end
  endtask

  task automatic send_noise(inout int unsigned sent);
    logic [ReadW-1:0] lvl;
    logic             rs;
    repeat ($urandom_range(4, 1)) begin
      rs = ($urandom_range(99) < 8);
      case ($urandom_range(9))
        0:       lvl = '0;
        1:       lvl = '1;
        default: lvl = ReadW'($urandom);
      endcase
      pace_sender();
      send_sample(make_sample(lvl, rs), 1'b0, '0);
      sent++;
    end
  endtask

  task automatic wait_for_reports();
    while (notch_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input snd_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_PATTERN_FIRST:  cfg_model.pattern_first  = PatW'(val);
      REG_PATTERN_SECOND: cfg_model.pattern_second = PatW'(val);
      REG_PATTERN_THIRD:  cfg_model.pattern_third  = PatW'(val);
      REG_STEP_SIZE:      cfg_model.step_size      = StepW'(val);
      REG_SWEEP_LIMIT:    cfg_model.sweep_limit    = FreqW'(val);
      default: ;
    endcase
  endtask

  task automatic program_phase(input int ph);
    snd_cfg_t c;
    case (ph)
      1: c = '{PatFirstRst, PatSecondRst, PatThirdRst, '0, 28'd50000000};
      2: c = '{8'h00, 8'hFF, PatW'($urandom), '1, '0};
      3: c = '{PatW'($urandom), PatW'($urandom), PatW'($urandom),
               StepW'($urandom_range(1 << 20, 1)), FreqW'($urandom)};
      4: c = '{PatW'($urandom), PatW'($urandom), PatW'($urandom), StepW'(1), '1};
      default: c = '{PatFirstRst, PatSecondRst, PatThirdRst, StepRst, LimitRst};
    endcase
    wait_for_reports();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(REG_PATTERN_FIRST,  CfgDataW'(c.pattern_first));
    write_reg(REG_PATTERN_SECOND, CfgDataW'(c.pattern_second));
    write_reg(REG_PATTERN_THIRD,  CfgDataW'(c.pattern_third));
    write_reg(REG_STEP_SIZE,      CfgDataW'(c.step_size));
    write_reg(REG_SWEEP_LIMIT,    CfgDataW'(c.sweep_limit));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5ns clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL sweep_notch_detector");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int          hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_notch_report();
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin
    int unsigned sent;
    logic        hold_done;
    mismatch_count = 0;
    hold_done      = 1'b0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= 1'b0;
    in_if.reading_a <= '0;
    in_if.reading_b <= '0;
    in_if.frequency <= '0;
    in_if.restart   <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_PATTERN_FIRST;
    cfg_if.data     <= '0;
    steady_flow     <= 1'b0;
    hold_requests   <= 0;
    cfg_model   = '{PatFirstRst, PatSecondRst, PatThirdRst, StepRst, LimitRst};
    hist_model  = '0;
    level_model = '1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      pace_sender();
      send_sample(directed_rows[i].sample, directed_rows[i].has_want, directed_rows[i].want);
    end
    in_if.valid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) program_phase(ph);
      sent = 0;
      while (sent < PhaseItems) begin
        steady_flow <= (ph == 3 && sent >= 30 && sent < 80) ||
                       (ph == 4 && sent >= 20 && sent < 100);
        if (ph == 3 && !hold_done && sent >= 30) begin
          hold_requests <= hold_requests + 1;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 65) send_shaped(sent);
        else send_noise(sent);
      end
      in_if.valid <= 1'b0;
      steady_flow <= 1'b0;
    end

    wait_for_reports();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASS sweep_notch_detector");
    else $display("FAIL sweep_notch_detector");
    $finish;
  end

endmodule
